FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL modules.
// Each use expects clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication: the consequent holds in the same cycle.
`define TCCH_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Non-overlapping implication: the consequent holds in the next cycle.
`define TCCH_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tcch_pkg.sv
`timescale 1ns / 1ps

package tcch_pkg;

    // Magnetometer axes are swapped and negated into the body frame.
    localparam bit ROTATE_AXES = 1'b1;

    localparam int ATAN_ENTRIES = 24;
    localparam int SQRT_STAGES  = 24;
    localparam int RAD_W        = 48;
    localparam int N8_W         = 24;
    localparam int XSUM_W       = 50;
    localparam int YD_W         = 34;
    localparam int TERM_W       = 58;
    localparam int CW           = 34;
    localparam int SCALE_MSB    = 28;

    localparam logic [2:0] REG_BIAS_X     = 3'd0;
    localparam logic [2:0] REG_BIAS_Y     = 3'd1;
    localparam logic [2:0] REG_BIAS_Z     = 3'd2;
    localparam logic [2:0] REG_SOFT_XX    = 3'd3;
    localparam logic [2:0] REG_SOFT_YY    = 3'd4;
    localparam logic [2:0] REG_SOFT_ZZ    = 3'd5;
    localparam logic [2:0] REG_SOFT_XY_XZ = 3'd6;
    localparam logic [2:0] REG_SOFT_YZ    = 3'd7;

    typedef struct packed {
        logic               valid;
        logic               degen;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [15:0] cz;
    } tcch_tag_t;

    typedef struct packed {
        tcch_tag_t                 tag;
        logic signed [XSUM_W-1:0]  x_term;
        logic signed [YD_W-1:0]    y_part;
    } tcch_dly_t;

    // Arctangent of 2^-i as a fraction of a full turn, 2^32 being one turn.
    function automatic logic [31:0] atan_turn(input int unsigned idx);
        logic [31:0] a;
        case (idx)
            0:       a = 32'h20000000;
            1:       a = 32'h12E4051E;
            2:       a = 32'h09FB385B;
            3:       a = 32'h051111D4;
            4:       a = 32'h028B0D43;
            5:       a = 32'h0145D7E1;
            6:       a = 32'h00A2F61E;
            7:       a = 32'h00517C55;
            8:       a = 32'h0028BE53;
            9:       a = 32'h00145F2F;
            10:      a = 32'h000A2F98;
            11:      a = 32'h000517CC;
            12:      a = 32'h00028BE6;
            13:      a = 32'h000145F3;
            14:      a = 32'h0000A2FA;
            15:      a = 32'h0000517D;
            16:      a = 32'h000028BE;
            17:      a = 32'h0000145F;
            18:      a = 32'h00000A30;
            19:      a = 32'h00000518;
            20:      a = 32'h0000028C;
            21:      a = 32'h00000146;
            22:      a = 32'h000000A3;
            23:      a = 32'h00000051;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

FILE: rtl/tcch_isqrt.sv
`timescale 1ns / 1ps

// Pipelined integer square root of n2 * 65536, one result bit per stage.
module tcch_isqrt
    import tcch_pkg::*;
(
    input  logic             clk,
    input  logic [31:0]      n2,
    output logic [N8_W-1:0]  root
);

    logic [RAD_W-1:0] rem_reg [0:SQRT_STAGES-2];
    logic [RAD_W-1:0] res_reg [0:SQRT_STAGES-1];

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        localparam logic [RAD_W:0] BIT_VAL = (RAD_W+1)'(1) << (RAD_W - 2 - 2 * k);
        logic [RAD_W-1:0] rem_in;
        logic [RAD_W-1:0] res_in;
        logic [RAD_W:0]   trial;
        logic             take;
        logic [RAD_W-1:0] res_next;

        if (k == 0) begin : g_first
            assign rem_in = {n2, 16'h0000};
            assign res_in = '0;
        end
        else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign res_in = res_reg[k-1];
        end

        assign trial    = {1'b0, res_in} + BIT_VAL;
        assign take     = ({1'b0, rem_in} >= trial);
        assign res_next = take ? ((res_in >> 1) + BIT_VAL[RAD_W-1:0]) : (res_in >> 1);

        always_ff @(posedge clk)
        begin
            res_reg[k] <= res_next;
        end

        if (k < SQRT_STAGES - 1) begin : g_rem
            logic [RAD_W-1:0] rem_next;
            assign rem_next = take ? (rem_in - trial[RAD_W-1:0]) : rem_in;
            always_ff @(posedge clk)
            begin
                rem_reg[k] <= rem_next;
            end
        end
    end

    assign root = res_reg[SQRT_STAGES-1][N8_W-1:0];

endmodule

FILE: rtl/tcch_cordic.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Scales the horizontal field terms and runs a pipelined vectoring CORDIC.
module tcch_cordic
    import tcch_pkg::*;
#(
    parameter int STEPS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  tcch_tag_t                in_tag,
    input  logic signed [TERM_W-1:0] x_in,
    input  logic signed [TERM_W-1:0] y_in,
    output tcch_tag_t                out_tag,
    output logic [15:0]              heading
);

    localparam int NS   = (STEPS < ATAN_ENTRIES) ? STEPS : ATAN_ENTRIES;
    localparam int SH_W = $clog2(TERM_W);
    localparam logic signed [CW-1:0] SCALE_LIM = CW'(1) <<< (SCALE_MSB + 1);

    // Magnitude stage.
    tcch_tag_t                tag1_reg;
    logic signed [TERM_W-1:0] x1_reg, y1_reg;
    logic [TERM_W-1:0]        orm_reg;
    logic                     zero1_reg;
    logic [TERM_W-1:0]        magx_next, magy_next;

    assign magx_next = x_in[TERM_W-1] ? TERM_W'(-x_in) : TERM_W'(x_in);
    assign magy_next = y_in[TERM_W-1] ? TERM_W'(-y_in) : TERM_W'(y_in);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
        end
        else
        begin
            tag1_reg <= in_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        x1_reg    <= x_in;
        y1_reg    <= y_in;
        orm_reg   <= magx_next | magy_next;
        zero1_reg <= (x_in == '0) && (y_in == '0);
    end

    // Shift search: the OR of both magnitudes has the same top bit as the larger one.
    tcch_tag_t                tag2_reg;
    logic signed [TERM_W-1:0] x2_reg, y2_reg;
    logic [SH_W-1:0]          s_reg;
    logic                     zero2_reg;
    logic [SH_W-1:0]          msb;
    logic [SH_W-1:0]          s_next;

    always_comb
    begin
        msb = '0;
        for (int i = 0; i < TERM_W; i++)
        begin
            if (orm_reg[i])
            begin
                msb = SH_W'(i);
            end
        end
        s_next = (msb > SH_W'(SCALE_MSB)) ? (msb - SH_W'(SCALE_MSB)) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag2_reg <= '0;
        end
        else
        begin
            tag2_reg <= tag1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x2_reg    <= x1_reg;
        y2_reg    <= y1_reg;
        s_reg     <= s_next;
        zero2_reg <= zero1_reg;
    end

    // Arithmetic shift stage.
    tcch_tag_t                tag3_reg;
    logic signed [CW-1:0]     x3_reg, y3_reg;
    logic                     zero3_reg;
    logic signed [TERM_W-1:0] xs_next, ys_next;

    assign xs_next = x2_reg >>> s_reg;
    assign ys_next = y2_reg >>> s_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag3_reg <= '0;
        end
        else
        begin
            tag3_reg <= tag2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x3_reg    <= xs_next[CW-1:0];
        y3_reg    <= ys_next[CW-1:0];
        zero3_reg <= zero2_reg;
    end

    // Half-turn pre-rotation puts x in the right half plane; then the steps.
    tcch_tag_t            tag_reg  [0:NS];
    logic                 zero_reg [0:NS];
    logic [31:0]          z_reg    [0:NS];
    logic signed [CW-1:0] x_reg    [0:NS-1];
    logic signed [CW-1:0] y_reg    [0:NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg[0] <= '0;
        end
        else
        begin
            tag_reg[0] <= tag3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        zero_reg[0] <= zero3_reg;
        if (x3_reg[CW-1])
        begin
            x_reg[0] <= -x3_reg;
            y_reg[0] <= -y3_reg;
            z_reg[0] <= 32'h80000000;
        end
        else
        begin
            x_reg[0] <= x3_reg;
            y_reg[0] <= y3_reg;
            z_reg[0] <= 32'h00000000;
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_step
        localparam logic [31:0] ANGLE = atan_turn(i);
        logic        up;
        logic [31:0] z_next;

        // A strictly positive y turns the vector clockwise.
        assign up     = !y_reg[i][CW-1] && (y_reg[i] != '0);
        assign z_next = up ? (z_reg[i] + ANGLE) : (z_reg[i] - ANGLE);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[i+1] <= '0;
            end
            else
            begin
                tag_reg[i+1] <= tag_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            z_reg[i+1]    <= z_next;
            zero_reg[i+1] <= zero_reg[i];
        end

        if (i < NS - 1) begin : g_xy
            logic signed [CW-1:0] dx, dy, x_next, y_next;
            assign dx     = y_reg[i] >>> i;
            assign dy     = x_reg[i] >>> i;
            assign x_next = up ? (x_reg[i] + dx) : (x_reg[i] - dx);
            assign y_next = up ? (y_reg[i] - dy) : (y_reg[i] + dy);
            always_ff @(posedge clk)
            begin
                x_reg[i+1] <= x_next;
                y_reg[i+1] <= y_next;
            end
        end
    end

    logic [31:0] z_round;

    // Round to the nearest 1/65536 turn; a full turn wraps to zero.
    assign z_round = z_reg[NS] + 32'h00008000;
    assign out_tag = tag_reg[NS];
    assign heading = (zero_reg[NS] || tag_reg[NS].degen) ? 16'h0000 : z_round[31:16];

    `TCCH_ASSERT_IMP(a_scaled_in_range, tag3_reg.valid, (x3_reg >= -SCALE_LIM) && (x3_reg < SCALE_LIM) && (y3_reg >= -SCALE_LIM) && (y3_reg < SCALE_LIM), "scaled CORDIC input out of range")

endmodule

FILE: rtl/tilt_compensated_compass_heading_top.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Tilt-compensated compass heading.
// A transaction enters when start is high and busy is low; busy stays low, so a
// new sample pair may be presented in every clock cycle. Each transaction carries
// one raw magnetometer and one accelerometer sample.
// Exactly one result per transaction appears on the result ports for a single
// cycle, marked by done. Most of its path lies in the 24-stage square-root
// pipeline that normalises the accelerometer and in the CORDIC, one stage per
// step (CORDIC_STEPS above 24 count as 24). Throughput is one transaction per
// cycle. Results leave in acceptance order.
// The receiver cannot hold results off; done must be taken when it is high.
// Calibration registers are written through cfg_wr_en, cfg_index and cfg_data.
// The user must write them only while no transaction is in flight; the block
// itself does not enforce this. Reset clears the pipeline and loads zero
// hard-iron offsets and an identity soft-iron matrix.
module tilt_compensated_compass_heading_top
    import tcch_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] mag_x,
    input  logic signed [15:0] mag_y,
    input  logic signed [15:0] mag_z,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output logic               done,
    output logic signed [15:0] cal_mag_x,
    output logic signed [15:0] cal_mag_y,
    output logic signed [15:0] cal_mag_z,
    output logic [15:0]        heading_turns,
    output logic               degenerate
);

    localparam int NS  = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int LAT = 33 + NS;
    localparam int DLY = SQRT_STAGES - 1;

    function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
        logic signed [15:0] r;
        if (v > 22'sd32767)
        begin
            r = 16'sh7FFF;
        end
        else if (v < -22'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

    assign busy = 1'b0;

    // Calibration registers.
    logic signed [15:0] bias_x_reg, bias_y_reg, bias_z_reg;
    logic signed [15:0] soft_xx_reg, soft_yy_reg, soft_zz_reg;
    logic signed [15:0] soft_xy_reg, soft_xz_reg, soft_yz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_x_reg  <= 16'sd0;
            bias_y_reg  <= 16'sd0;
            bias_z_reg  <= 16'sd0;
            soft_xx_reg <= 16'sd16384;
            soft_yy_reg <= 16'sd16384;
            soft_zz_reg <= 16'sd16384;
            soft_xy_reg <= 16'sd0;
            soft_xz_reg <= 16'sd0;
            soft_yz_reg <= 16'sd0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_BIAS_X:     bias_x_reg  <= cfg_data[15:0];
                REG_BIAS_Y:     bias_y_reg  <= cfg_data[15:0];
                REG_BIAS_Z:     bias_z_reg  <= cfg_data[15:0];
                REG_SOFT_XX:    soft_xx_reg <= cfg_data[15:0];
                REG_SOFT_YY:    soft_yy_reg <= cfg_data[15:0];
                REG_SOFT_ZZ:    soft_zz_reg <= cfg_data[15:0];
                REG_SOFT_XY_XZ:
                begin
                    soft_xy_reg <= cfg_data[15:0];
                    soft_xz_reg <= cfg_data[31:16];
                end
                REG_SOFT_YZ:    soft_yz_reg <= cfg_data[15:0];
                default:        ;
            endcase
        end
    end

    // Stage 1: axis mapping and hard-iron subtraction.
    logic               v1_reg;
    logic signed [17:0] bx_reg, by_reg, bz_reg;
    logic signed [15:0] ax1_reg, ay1_reg, az1_reg;
    logic signed [16:0] mx_next, my_next, mz_next;
    logic               accept;

    assign accept = start && !busy;

    always_comb
    begin
        if (ROTATE_AXES)
        begin
            mx_next = -17'(mag_y);
            my_next = -17'(mag_x);
            mz_next = -17'(mag_z);
        end
        else
        begin
            mx_next = 17'(mag_x);
            my_next = 17'(mag_y);
            mz_next = 17'(mag_z);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        bx_reg  <= 18'(mx_next) - 18'(bias_x_reg);
        by_reg  <= 18'(my_next) - 18'(bias_y_reg);
        bz_reg  <= 18'(mz_next) - 18'(bias_z_reg);
        ax1_reg <= accel_x;
        ay1_reg <= accel_y;
        az1_reg <= accel_z;
    end

    // Stage 2: soft-iron products and accelerometer products.
    logic               v2_reg;
    logic signed [33:0] pxx_reg, pxy_reg, pxz_reg;
    logic signed [33:0] pyx_reg, pyy_reg, pyz_reg;
    logic signed [33:0] pzx_reg, pzy_reg, pzz_reg;
    logic signed [31:0] ax2_reg, ay2_reg, az2_reg, axay2_reg;
    logic signed [32:0] axaz2_reg;
    logic signed [16:0] azabs2_reg;
    logic signed [15:0] ay_s2_reg;
    logic               azero2_reg;
    logic signed [16:0] azabs_next;

    assign azabs_next = az1_reg[15] ? -17'(az1_reg) : 17'(az1_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pxx_reg    <= 34'(soft_xx_reg) * 34'(bx_reg);
        pxy_reg    <= 34'(soft_xy_reg) * 34'(by_reg);
        pxz_reg    <= 34'(soft_xz_reg) * 34'(bz_reg);
        pyx_reg    <= 34'(soft_xy_reg) * 34'(bx_reg);
        pyy_reg    <= 34'(soft_yy_reg) * 34'(by_reg);
        pyz_reg    <= 34'(soft_yz_reg) * 34'(bz_reg);
        pzx_reg    <= 34'(soft_xz_reg) * 34'(bx_reg);
        pzy_reg    <= 34'(soft_yz_reg) * 34'(by_reg);
        pzz_reg    <= 34'(soft_zz_reg) * 34'(bz_reg);
        ax2_reg    <= 32'(ax1_reg) * 32'(ax1_reg);
        ay2_reg    <= 32'(ay1_reg) * 32'(ay1_reg);
        az2_reg    <= 32'(az1_reg) * 32'(az1_reg);
        axay2_reg  <= 32'(ax1_reg) * 32'(ay1_reg);
        axaz2_reg  <= 33'(ax1_reg) * 33'(azabs_next);
        azabs2_reg <= azabs_next;
        ay_s2_reg  <= ay1_reg;
        azero2_reg <= (ax1_reg == 16'sd0) && (ay1_reg == 16'sd0) && (az1_reg == 16'sd0);
    end

    // Stage 3: row sums with round-half-up and saturation; squared norms.
    logic               v3_reg;
    logic signed [15:0] cx3_reg, cy3_reg, cz3_reg;
    logic signed [32:0] q3_reg;
    logic [31:0]        n2_reg;
    logic signed [31:0] axay3_reg;
    logic signed [32:0] axaz3_reg;
    logic signed [16:0] azabs3_reg;
    logic signed [15:0] ay3_reg;
    logic               azero3_reg;
    logic signed [35:0] sx_next, sy_next, sz_next;
    logic signed [35:0] rx_next, ry_next, rz_next;

    always_comb
    begin
        sx_next = 36'(pxx_reg) + 36'(pxy_reg) + 36'(pxz_reg) + 36'sd8192;
        sy_next = 36'(pyx_reg) + 36'(pyy_reg) + 36'(pyz_reg) + 36'sd8192;
        sz_next = 36'(pzx_reg) + 36'(pzy_reg) + 36'(pzz_reg) + 36'sd8192;
        rx_next = sx_next >>> 14;
        ry_next = sy_next >>> 14;
        rz_next = sz_next >>> 14;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cx3_reg    <= sat16(rx_next[21:0]);
        cy3_reg    <= sat16(ry_next[21:0]);
        cz3_reg    <= sat16(rz_next[21:0]);
        q3_reg     <= 33'(ay2_reg) + 33'(az2_reg);
        n2_reg     <= {1'b0, ax2_reg[30:0]} + {1'b0, ay2_reg[30:0]} + {1'b0, az2_reg[30:0]};
        axay3_reg  <= axay2_reg;
        axaz3_reg  <= axaz2_reg;
        azabs3_reg <= azabs2_reg;
        ay3_reg    <= ay_s2_reg;
        azero3_reg <= azero2_reg;
    end

    // Square root of n2 * 65536 runs alongside stages 4 onwards.
    logic [N8_W-1:0] n8;

    tcch_isqrt u_isqrt (
        .clk  (clk),
        .n2   (n2_reg),
        .root (n8)
    );

    // Stage 4: tilt products.
    tcch_tag_t          tag4_reg;
    logic signed [48:0] p1_reg;
    logic signed [47:0] p2_reg;
    logic signed [48:0] p3_reg;
    logic signed [32:0] y1_reg;
    logic signed [31:0] y2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag4_reg <= '0;
        end
        else
        begin
            tag4_reg.valid <= v3_reg;
            tag4_reg.degen <= azero3_reg ||
                              ((cx3_reg == 16'sd0) && (cy3_reg == 16'sd0) && (cz3_reg == 16'sd0));
            tag4_reg.cx    <= cx3_reg;
            tag4_reg.cy    <= cy3_reg;
            tag4_reg.cz    <= cz3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg <= 49'(cx3_reg) * 49'(q3_reg);
        p2_reg <= 48'(cy3_reg) * 48'(axay3_reg);
        p3_reg <= 49'(cz3_reg) * 49'(axaz3_reg);
        y1_reg <= 33'(cy3_reg) * 33'(azabs3_reg);
        y2_reg <= 32'(cz3_reg) * 32'(ay3_reg);
    end

    // Stage 5 and the delay line that waits for the square root.
    tcch_dly_t dly_reg [0:DLY-1];
    tcch_dly_t d5_next;

    always_comb
    begin
        d5_next.tag    = tag4_reg;
        d5_next.x_term = 50'(p1_reg) - 50'(p2_reg) - 50'(p3_reg);
        d5_next.y_part = 34'(y1_reg) - 34'(y2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DLY; k++)
            begin
                dly_reg[k] <= '0;
            end
        end
        else
        begin
            dly_reg[0] <= d5_next;
            for (int k = 1; k < DLY; k++)
            begin
                dly_reg[k] <= dly_reg[k-1];
            end
        end
    end

    // Scale Y by the accelerometer norm and X by 256.
    tcch_tag_t                tagy_reg;
    logic signed [TERM_W-1:0] xt_reg, yt_reg;
    logic signed [58:0]       yprod_next;

    assign yprod_next = 59'(dly_reg[DLY-1].y_part) * 59'($signed({1'b0, n8}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tagy_reg <= '0;
        end
        else
        begin
            tagy_reg <= dly_reg[DLY-1].tag;
        end
    end

    always_ff @(posedge clk)
    begin
        xt_reg <= {dly_reg[DLY-1].x_term, 8'h00};
        yt_reg <= yprod_next[TERM_W-1:0];
    end

    tcch_tag_t   cor_tag;
    logic [15:0] cor_heading;

    tcch_cordic #(
        .STEPS (NS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_tag  (tagy_reg),
        .x_in    (xt_reg),
        .y_in    (yt_reg),
        .out_tag (cor_tag),
        .heading (cor_heading)
    );

    // Result register.
    logic               done_reg;
    logic signed [15:0] cal_x_reg, cal_y_reg, cal_z_reg;
    logic [15:0]        heading_reg;
    logic               degen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cor_tag.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        cal_x_reg   <= cor_tag.cx;
        cal_y_reg   <= cor_tag.cy;
        cal_z_reg   <= cor_tag.cz;
        heading_reg <= cor_heading;
        degen_reg   <= cor_tag.degen;
    end

    assign done          = done_reg;
    assign cal_mag_x     = cal_x_reg;
    assign cal_mag_y     = cal_y_reg;
    assign cal_mag_z     = cal_z_reg;
    assign heading_turns = heading_reg;
    assign degenerate    = degen_reg;

    `TCCH_ASSERT_IMP(a_result_follows, accept, ##LAT done, "accepted transaction produced no result")
    `TCCH_ASSERT_IMP(a_no_extra_result, done, $past(accept, LAT), "result without a matching transaction")
    `TCCH_ASSERT_IMP(a_degen_heading, done && degenerate, heading_turns == 16'h0000, "degenerate result carries a heading")

endmodule
